/* design/sensor_frame_crc_check_core_macros.svh */
// Assertion macros for the sensor frame CRC check core
`ifndef SENSOR_FRAME_CRC_CHECK_CORE_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_CORE_MACROS_SVH

// Same-cycle implication
`define SFCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcc assertion failed");

// Next-cycle implication
`define SFCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcc assertion failed");

`endif

/* design/sfcc_pkg.sv */
// Shared types, constants and CRC function for the sensor frame CRC check core
`default_nettype none

package sfcc_pkg;

    localparam int FRAME_LEN_DEF = 8;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_CRC = 2'd1,
        STATUS_BUS = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
        logic       bus_error;
    } in_item_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/sfcc_in_stage.sv */
// Input register stage of the sensor frame CRC check core
`default_nettype none

module sfcc_in_stage
    import sfcc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire in_item_t s_item,
    output logic          item_valid,
    output in_item_t      item,
    input  wire logic     item_take
);

    logic     in_valid_reg;
    in_item_t item_reg;

    assign s_tready   = !in_valid_reg || item_take;
    assign item_valid = in_valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

/* design/sfcc_frame_check.sv */
// Frame state, CRC update and result register of the sensor frame CRC check core
`default_nettype none

module sfcc_frame_check
    import sfcc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    input  wire in_item_t item,
    output logic          item_take,
    output logic          res_valid,
    input  wire logic     res_ready,
    output logic [15:0]   res_humidity,
    output logic [15:0]   res_temperature,
    output logic [1:0]    res_status
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] HUM_HI_IDX  = IDX_W'(2);
    localparam logic [IDX_W-1:0] HUM_LO_IDX  = IDX_W'(3);
    localparam logic [IDX_W-1:0] TEMP_HI_IDX = IDX_W'(4);
    localparam logic [IDX_W-1:0] TEMP_LO_IDX = IDX_W'(5);
    localparam logic [IDX_W-1:0] CRC_LO_IDX  = IDX_W'(FRAME_LEN - 2);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(FRAME_LEN - 1);

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      hum_reg, hum_next;
    logic [15:0]      temp_reg, temp_next;
    logic [7:0]       crc_lo_reg, crc_lo_next;
    logic             err_reg, err_next;

    logic             out_valid_reg;
    logic [15:0]      out_hum_reg;
    logic [15:0]      out_temp_reg;
    frame_status_t    out_status_reg;

    logic [IDX_W-1:0] idx;
    logic             is_last;
    frame_status_t    status;

    always_comb
    begin
        idx             = item.frame_start ? '0 : byte_index_reg;
        crc_next        = item.frame_start ? CRC_INIT : crc_reg;
        hum_next        = item.frame_start ? 16'h0000 : hum_reg;
        temp_next       = item.frame_start ? 16'h0000 : temp_reg;
        crc_lo_next     = item.frame_start ? 8'h00 : crc_lo_reg;
        err_next        = (item.frame_start ? 1'b0 : err_reg) | item.bus_error;
        is_last         = (idx == LAST_IDX);
        byte_index_next = idx + IDX_W'(1);

        if (idx < CRC_LO_IDX)
        begin
            crc_next = crc_byte(crc_next, item.rx_byte);
        end

        case (idx)
            HUM_HI_IDX:  hum_next[15:8]  = item.rx_byte;
            HUM_LO_IDX:  hum_next[7:0]   = item.rx_byte;
            TEMP_HI_IDX: temp_next[15:8] = item.rx_byte;
            TEMP_LO_IDX: temp_next[7:0]  = item.rx_byte;
            CRC_LO_IDX:  crc_lo_next     = item.rx_byte;
            default:     ;
        endcase

        if (err_next)
        begin
            status = STATUS_BUS;
        end
        else if ({item.rx_byte, crc_lo_next} != crc_next)
        begin
            status = STATUS_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end

        item_take = item_valid && (!is_last || !out_valid_reg || res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            crc_reg        <= CRC_INIT;
            hum_reg        <= 16'h0000;
            temp_reg       <= 16'h0000;
            crc_lo_reg     <= 8'h00;
            err_reg        <= 1'b0;
        end
        else if (item_take)
        begin
            if (is_last)
            begin
                byte_index_reg <= '0;
                crc_reg        <= CRC_INIT;
                hum_reg        <= 16'h0000;
                temp_reg       <= 16'h0000;
                crc_lo_reg     <= 8'h00;
                err_reg        <= 1'b0;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                crc_reg        <= crc_next;
                hum_reg        <= hum_next;
                temp_reg       <= temp_next;
                crc_lo_reg     <= crc_lo_next;
                err_reg        <= err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_take && is_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && is_last)
        begin
            out_hum_reg    <= (status == STATUS_OK) ? hum_next : 16'h0000;
            out_temp_reg   <= (status == STATUS_OK) ? temp_next : 16'h0000;
            out_status_reg <= status;
        end
    end

    assign res_valid       = out_valid_reg;
    assign res_humidity    = out_hum_reg;
    assign res_temperature = out_temp_reg;
    assign res_status      = out_status_reg;

endmodule

`default_nettype wire

/* design/sensor_frame_crc_check_core.sv */
// Top level of the sensor frame CRC check core
// Checks the eight-byte response frame of a temperature and humidity sensor, one byte per
// item: a reflected CRC-16 (polynomial 0xA001, start value 0xFFFF) runs over bytes 0 to 5
// and is compared with the CRC in bytes 6 and 7, low byte first. After byte 7 one item
// leaves with humidity and temperature in raw tenths (zero unless the status is valid) and
// a status: 0 valid, 1 CRC mismatch, 2 bus error seen during the frame. A start flag in the
// middle of a frame drops that frame. The block takes one byte per cycle, stalls apart; each
// last byte passes an input register and then a result register before its result is valid.
// Input stalls only when a frame's last byte waits behind a result that has not been taken.
`default_nettype none

module sensor_frame_crc_check_core
    import sfcc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [0] frame_start, [1] bus_error
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths
    output logic [1:0]       m_tuser    // [1:0] frame_status
);

    in_item_t    s_item;
    in_item_t    item;
    logic        item_valid;
    logic        item_take;
    logic [15:0] res_humidity;
    logic [15:0] res_temperature;

    assign s_item.rx_byte     = s_tdata;
    assign s_item.frame_start = s_tuser[0];
    assign s_item.bus_error   = s_tuser[1];

    sfcc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    sfcc_frame_check #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item            (item),
        .item_take       (item_take),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .res_humidity    (res_humidity),
        .res_temperature (res_temperature),
        .res_status      (m_tuser)
    );

    assign m_tdata = {res_temperature, res_humidity};

endmodule

`default_nettype wire

/* design/sfcc_checker.sv */
// Port assertions for the sensor frame CRC check core and their bind
`default_nettype none

`include "sensor_frame_crc_check_core_macros.svh"

module sfcc_checker
    import sfcc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    `SFCC_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `SFCC_ASSERT_NEXT(a_out_data_holds, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `SFCC_ASSERT_IMPL(a_status_legal, clk, rst_n, m_tvalid, m_tuser == STATUS_OK || m_tuser == STATUS_CRC || m_tuser == STATUS_BUS)
    `SFCC_ASSERT_IMPL(a_bad_frame_zero, clk, rst_n, m_tvalid && m_tuser != STATUS_OK, m_tdata == 32'h0)

endmodule

bind sensor_frame_crc_check_core sfcc_checker u_sfcc_checker (.*);

`default_nettype wire
